// ----- hw/rtl/mrpn_pkg.sv -----
// Shared types and constants of the multibase RPN stack calculator.
// Used by the controller, the datapath and the top level; no dependencies.
package mrpn_pkg;

  // Token kinds as reported on the result channel
  localparam logic [2:0] KIND_NUM = 3'd0;
  localparam logic [2:0] KIND_ADD = 3'd1;
  localparam logic [2:0] KIND_SUB = 3'd2;
  localparam logic [2:0] KIND_MUL = 3'd3;
  localparam logic [2:0] KIND_DIV = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DZ    = 2'd3;

  // Characters used for classification
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ONE  = 8'h31;

  // Stack update applied when a token finishes
  typedef enum logic [1:0] {
    CM_NONE = 2'd0,
    CM_PUSH = 2'd1,
    CM_POP  = 2'd2
  } commit_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;     // take one character
    logic       rd_issue;   // read second entry from the stack RAM
    logic       op_start;   // latch operands, start the operation
    logic       mul_step;   // one multiply/accumulate step
    logic [1:0] mul_idx;
    logic       div_step;   // one restoring divide step
    logic       div_fin;    // sign fix of the quotient
    logic       finish;     // commit stack, load result, clear token
    commit_t    commit;
    logic [1:0] status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       full;
    logic       lt2;
    logic       b_zero;
  } sts_t;

  // Hex digit value; other bytes count as code minus 0x30, wrapping
  function automatic logic [63:0] hex_digit(input logic [7:0] c);
    logic [63:0] v;
    if (c >= 8'h41 && c <= 8'h46) v = {56'd0, c - 8'h37};
    else if (c >= 8'h61 && c <= 8'h66) v = {56'd0, c - 8'h57};
    else v = {56'd0, c} - 64'h30;
    return v;
  endfunction

endpackage

// ----- hw/rtl/mrpn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrpn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- hw/rtl/mrpn_ctrl.sv -----
// Controller state machine of the RPN calculator.
// Depends on mrpn_pkg; drives the datapath through cmd_t, reads sts_t.
module mrpn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_token_end,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mrpn_pkg::sts_t sts,
  output mrpn_pkg::cmd_t cmd
);
  import mrpn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_OPRD = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_DFIN = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  status_r, status_nxt;
  commit_t     commit_r, commit_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    commit_nxt    = commit_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.commit    = commit_r;
    cmd.status    = status_r;
    cmd.mul_idx   = cnt_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_token_end) state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.kind == KIND_NUM) begin
          status_nxt = sts.full ? ST_OVER : ST_OK;
          commit_nxt = sts.full ? CM_NONE : CM_PUSH;
          state_nxt  = S_FIN;
        end else if (sts.lt2) begin
          status_nxt = ST_UNDER;
          commit_nxt = CM_NONE;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_OPRD;
        end
      end
      S_OPRD: begin
        cmd.op_start = 1'b1;
        cnt_nxt      = '0;
        status_nxt   = ST_OK;
        commit_nxt   = CM_POP;
        priority if (sts.kind == KIND_DIV && sts.b_zero) begin
          status_nxt = ST_DZ;
          commit_nxt = CM_NONE;
          state_nxt  = S_FIN;
        end else if (sts.kind == KIND_DIV) begin
          state_nxt = S_DIV;
        end else if (sts.kind == KIND_MUL) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      status_r    <= ST_OK;
      commit_r    <= CM_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      commit_r    <= commit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ----- hw/rtl/mrpn_datapath.sv -----
// Datapath: token parser, stack (cached top plus RAM), multiply and divide
// units and the result register. Depends on mrpn_pkg and mrpn_ram.
module mrpn_datapath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_ch,
  input  logic               in_new_expression,
  input  mrpn_pkg::cmd_t     cmd,
  output mrpn_pkg::sts_t     sts,
  output logic signed [63:0] out_top_value,
  output logic [5:0]         out_stack_depth,
  output logic [2:0]         out_token_kind,
  output logic [1:0]         out_status
);
  import mrpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // Token state
  logic [7:0]  prefix_r [3];
  logic [1:0]  char_idx_r;
  logic [63:0] bin_r, hex_r, dec_r;
  logic        dstop_r;

  // Stack
  logic [CW-1:0] count_r, count_nxt;
  logic [63:0]   tos_r, tos_nxt;

  // Operation registers
  logic [63:0] res_r, prod_r, quo_r, rem_r, dvs_r;
  logic        neg_r;
  logic [31:0] a_hi_r;

  // Output payload
  logic [63:0] out_top_r;
  logic [5:0]  out_depth_r;
  logic [2:0]  out_kind_r;
  logic [1:0]  out_status_r;

  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0] ram_rdata;

  logic [2:0]  kind;
  logic [63:0] push_val, a_mag, b_mag, div_sh;
  logic        is_digit;

  // Classification from the first characters of the token
  always_comb begin
    kind = KIND_NUM;
    if (char_idx_r == 2'd3) begin
      priority if (prefix_r[0] == "a" && prefix_r[1] == "d" && prefix_r[2] == "d")
        kind = KIND_ADD;
      else if (prefix_r[0] == "s" && prefix_r[1] == "u" && prefix_r[2] == "b")
        kind = KIND_SUB;
      else if (prefix_r[0] == "m" && prefix_r[1] == "u" && prefix_r[2] == "l")
        kind = KIND_MUL;
      else if (prefix_r[0] == "d" && prefix_r[1] == "i" && prefix_r[2] == "v")
        kind = KIND_DIV;
      else
        kind = KIND_NUM;
    end
  end

  // Number value by prefix
  always_comb begin
    priority if (char_idx_r >= 2'd2 && prefix_r[0] == "0" && prefix_r[1] == "b")
      push_val = bin_r;
    else if (char_idx_r >= 2'd2 && prefix_r[0] == "0" && prefix_r[1] == "x")
      push_val = hex_r;
    else
      push_val = dec_r;
  end

  assign sts.kind   = kind;
  assign sts.full   = (count_r >= DEPTH_C);
  assign sts.lt2    = (count_r < CW'(2));
  assign sts.b_zero = (tos_r == 64'd0);

  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r   <= '{default: 8'd0};
      char_idx_r <= '0;
      bin_r      <= '0;
      hex_r      <= '0;
      dec_r      <= '0;
      dstop_r    <= 1'b0;
    end else if (cmd.finish) begin
      prefix_r   <= '{default: 8'd0};
      char_idx_r <= '0;
      bin_r      <= '0;
      hex_r      <= '0;
      dec_r      <= '0;
      dstop_r    <= 1'b0;
    end else if (cmd.accept) begin
      if (char_idx_r >= 2'd2) hex_r <= (hex_r << 4) + hex_digit(in_ch);
      if (char_idx_r != 2'd3) begin
        prefix_r[char_idx_r] <= in_ch;
        char_idx_r           <= char_idx_r + 2'd1;
      end
      bin_r <= (bin_r << 1) + {63'd0, in_ch == CH_ONE};
      if (!dstop_r) begin
        if (is_digit) dec_r <= (dec_r << 3) + (dec_r << 1) + {56'd0, in_ch - CH_ZERO};
        else dstop_r <= 1'b1;
      end
    end
  end

  // Stack commit
  always_comb begin
    count_nxt = count_r;
    tos_nxt   = tos_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(count_r - CW'(1));
    if (cmd.accept && in_new_expression) count_nxt = '0;
    if (cmd.finish) begin
      unique case (cmd.commit)
        CM_PUSH: begin
          ram_we    = (count_r != '0);
          tos_nxt   = push_val;
          count_nxt = count_r + CW'(1);
        end
        CM_POP: begin
          tos_nxt   = res_r;
          count_nxt = count_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign ram_re    = cmd.rd_issue;
  assign ram_raddr = AW'(count_r - CW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
  end

  mrpn_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand magnitudes for signed division
  assign a_mag  = ram_rdata[63] ? 64'd0 - ram_rdata : ram_rdata;
  assign b_mag  = tos_r[63] ? 64'd0 - tos_r : tos_r;
  assign div_sh = {rem_r[62:0], quo_r[63]};

  // Arithmetic: add/sub direct, mul by 32x32 partial products, div restoring
  always_ff @(posedge clk) begin
    if (cmd.op_start) begin
      unique case (kind)
        KIND_ADD: res_r <= ram_rdata + tos_r;
        KIND_SUB: res_r <= ram_rdata - tos_r;
        default:  res_r <= 64'd0;
      endcase
      quo_r  <= a_mag;
      prod_r <= {32'd0, ram_rdata[31:0]};
      rem_r  <= 64'd0;
      dvs_r  <= b_mag;
      neg_r  <= ram_rdata[63] ^ tos_r[63];
    end
    if (cmd.mul_step) begin
      unique case (cmd.mul_idx)
        2'd0: quo_r <= prod_r[31:0] * tos_r[31:0];
        2'd1: quo_r <= prod_r[31:0] * tos_r[63:32];
        2'd2: quo_r <= rem_r[31:0] * tos_r[31:0];
        default: quo_r <= 64'd0;
      endcase
      unique case (cmd.mul_idx)
        2'd1:    res_r <= res_r + quo_r;
        2'd2,
        2'd3:    res_r <= res_r + {quo_r[31:0], 32'd0};
        default: res_r <= res_r;
      endcase
      if (cmd.mul_idx == 2'd0) rem_r <= {32'd0, a_hi_r};
    end
    if (cmd.div_step) begin
      if (div_sh >= dvs_r) begin
        rem_r <= div_sh - dvs_r;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= div_sh;
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (cmd.div_fin) res_r <= neg_r ? 64'd0 - quo_r : quo_r;
  end

  // High half of the first operand (the second stack entry) for the multiplier
  always_ff @(posedge clk) begin
    if (cmd.op_start) a_hi_r <= ram_rdata[63:32];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_top_r    <= (count_nxt != '0) ? tos_nxt : 64'd0;
      out_depth_r  <= 6'(count_nxt);
      out_kind_r   <= kind;
      out_status_r <= cmd.status;
    end
  end

  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_token_kind  = out_kind_r;
  assign out_status      = out_status_r;
endmodule

// ----- hw/rtl/multibase_rpn_stack_calculator.sv -----
// Top level of the multibase RPN stack calculator.
// Depends on mrpn_pkg, mrpn_ctrl, mrpn_datapath (which holds mrpn_ram).
//
// Usage: characters of RPN tokens enter on the in_ channel (valid/stall),
// one per transfer; in_token_end marks a token's last character and
// in_new_expression empties the stack before its character is handled.
// Each token end yields one transfer on the out_ channel with the top of
// stack, depth, token kind and status. Other characters yield none.
// A character that is not a token end enters the token state. A token end
// is checked, and a number or an error found from depth alone committed;
// add, sub and a zero divisor first take one stack RAM read, mul then four
// steps of a shared 32x32 multiplier and div a 64-step restoring divider.
// The result sits in an output register; the next character is accepted
// as soon as the token has been committed, even while that result waits.
// A stalled result holds the block in its final step only if a newer
// result must be written over it.
// Reset (synchronous, rst_n low) empties the stack and clears the token
// state; the stack RAM needs no clearing pass.
module multibase_rpn_stack_calculator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_token_end,
  input  logic               in_new_expression,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_top_value,
  output logic [5:0]         out_stack_depth,
  output logic [2:0]         out_token_kind,
  output logic [1:0]         out_status
);
  import mrpn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mrpn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_token_end (in_token_end),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mrpn_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .in_new_expression (in_new_expression),
    .cmd               (cmd),
    .sts               (sts),
    .out_top_value     (out_top_value),
    .out_stack_depth   (out_stack_depth),
    .out_token_kind    (out_token_kind),
    .out_status        (out_status)
  );

  // Numbers never underflow or divide by zero
  a_num_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_NUM |-> out_status == ST_OK || out_status == ST_OVER)
    else $error("number token with operator status");

  // Divide by zero only on div
  a_dz_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DZ |-> out_token_kind == KIND_DIV)
    else $error("divide by zero on a non-div token");

  // Overflow only on a push
  a_over_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVER |-> out_token_kind == KIND_NUM)
    else $error("overflow on an operator token");
endmodule
